// ----- design/sxt_pkg.sv -----
// Shared types and constants for the s-expression tokenizer.
// No dependencies; imported by every module of the block.
package sxt_pkg;

  localparam logic [31:0] MAX_TEXT_LEN = 32'd65535;
  localparam logic [15:0] POS_CAP =
    (MAX_TEXT_LEN > 32'd65535) ? 16'hFFFF : MAX_TEXT_LEN[15:0];

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [3:0] KIND_OPEN      = 4'd0;
  localparam logic [3:0] KIND_CLOSE     = 4'd1;
  localparam logic [3:0] KIND_DOT       = 4'd2;
  localparam logic [3:0] KIND_QUOTE     = 4'd3;
  localparam logic [3:0] KIND_BACKQUOTE = 4'd4;
  localparam logic [3:0] KIND_COMMA     = 4'd5;
  localparam logic [3:0] KIND_STRING    = 4'd6;
  localparam logic [3:0] KIND_SYMBOL    = 4'd7;
  localparam logic [3:0] KIND_END       = 4'd8;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_final;
  } item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] end_offset;
    logic        run_last;
  } token_t;

  // One token inside a queue entry (run_last is implied by slot position).
  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start_offset;
    logic [15:0] end_offset;
  } slot_t;

  // All tokens caused by one input byte, 1 to 3 of them.
  typedef struct packed {
    logic [1:0]        count;
    slot_t [2:0]       slot;
  } entry_t;

endpackage

// ----- design/sxt_front.sv -----
// Front end: classifies each byte, tracks scan mode and offsets, and
// builds a queue entry with every token the byte produces. Uses sxt_pkg.
module sxt_front import sxt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  output logic   item_ready,
  input  item_t  item,
  input  logic   q_full,
  output logic   push,
  output entry_t entry
);

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_COMMENT = 2'd1;
  localparam logic [1:0] MODE_STRING  = 2'd2;
  localparam logic [1:0] MODE_SYMBOL  = 2'd3;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_BQ    = 8'h60;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  logic [1:0]  scan_mode, scan_mode_next;
  logic [15:0] token_start, token_start_next;
  logic [15:0] position, position_next;

  logic        accept;
  logic [15:0] pe;
  logic        is_ws, is_forb, is_single, consumed;
  logic [3:0]  single_kind;
  logic [1:0]  mode_v;
  logic [15:0] ts_v;
  logic [1:0]  n;
  slot_t [2:0] slots;

  assign item_ready = !q_full;
  assign accept     = item_valid && item_ready;
  assign pe         = (position < POS_CAP) ? position + 16'd1 : POS_CAP;

  always_comb begin
    is_ws = (item.char_code == CH_SPACE) ||
            (item.char_code >= 8'd9 && item.char_code <= 8'd13);
    is_forb = (item.char_code == CH_OPEN) || (item.char_code == CH_CLOSE) ||
              (item.char_code == CH_DQ) || (item.char_code == CH_SQ) ||
              (item.char_code == CH_SEMI) || (item.char_code == CH_BQ) ||
              (item.char_code == CH_COMMA);
    is_single = 1'b1;
    unique case (item.char_code)
      CH_OPEN:  single_kind = KIND_OPEN;
      CH_CLOSE: single_kind = KIND_CLOSE;
      CH_DOT:   single_kind = KIND_DOT;
      CH_SQ:    single_kind = KIND_QUOTE;
      CH_BQ:    single_kind = KIND_BACKQUOTE;
      CH_COMMA: single_kind = KIND_COMMA;
      default: begin
        single_kind = KIND_OPEN;
        is_single   = 1'b0;
      end
    endcase
  end

  // Token builder: at most three appends per byte.
  always_comb begin
    mode_v   = scan_mode;
    ts_v     = token_start;
    consumed = 1'b0;
    n        = 2'd0;
    slots    = '0;

    unique case (scan_mode)
      MODE_SYMBOL: begin
        if (is_ws || is_forb) begin
          slots[n] = '{kind: KIND_SYMBOL, start_offset: token_start, end_offset: position};
          n = n + 2'd1;
          mode_v = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (item.char_code == CH_DQ) begin
          slots[n] = '{kind: KIND_STRING, start_offset: token_start, end_offset: pe};
          n = n + 2'd1;
          mode_v = MODE_IDLE;
        end
        consumed = 1'b1;
      end
      MODE_COMMENT: begin
        if (item.char_code == CH_NL) mode_v = MODE_IDLE;
        consumed = 1'b1;
      end
      default: mode_v = MODE_IDLE;
    endcase

    if (mode_v == MODE_IDLE && !consumed) begin
      if (is_ws) begin
        mode_v = MODE_IDLE;
      end else if (item.char_code == CH_SEMI) begin
        mode_v = MODE_COMMENT;
      end else if (item.char_code == CH_DQ) begin
        mode_v = MODE_STRING;
        ts_v   = position;
      end else if (is_single) begin
        slots[n] = '{kind: single_kind, start_offset: position, end_offset: pe};
        n = n + 2'd1;
      end else begin
        mode_v = MODE_SYMBOL;
        ts_v   = position;
      end
    end

    if (item.is_final) begin
      if (mode_v == MODE_SYMBOL) begin
        slots[n] = '{kind: KIND_SYMBOL, start_offset: ts_v, end_offset: pe};
        n = n + 2'd1;
      end else if (mode_v == MODE_STRING) begin
        slots[n] = '{kind: KIND_STRING, start_offset: ts_v, end_offset: pe};
        n = n + 2'd1;
      end
      slots[n] = '{kind: KIND_END, start_offset: pe, end_offset: pe};
      n = n + 2'd1;
      scan_mode_next   = MODE_IDLE;
      token_start_next = 16'd0;
      position_next    = 16'd0;
    end else begin
      scan_mode_next   = mode_v;
      token_start_next = ts_v;
      position_next    = pe;
    end
  end

  assign push        = accept && (n != 2'd0);
  assign entry.count = n;
  assign entry.slot  = slots;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode   <= MODE_IDLE;
      token_start <= 16'd0;
      position    <= 16'd0;
    end else if (accept) begin
      scan_mode   <= scan_mode_next;
      token_start <= token_start_next;
      position    <= position_next;
    end
  end

endmodule

// ----- design/sxt_queue.sv -----
// Short FIFO of token entries between front and back end.
// Uses sxt_pkg for the entry type.
module sxt_queue import sxt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   empty,
  output logic   full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_FULL);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)      count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

endmodule

// ----- design/sxt_back.sv -----
// Back end: walks the tokens of the head entry one per transfer into a
// registered output stage. Uses sxt_pkg.
module sxt_back import sxt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  entry_t head,
  input  logic   q_empty,
  output logic   pop,
  output logic   token_valid,
  input  logic   token_ready,
  output token_t token
);

  logic [1:0] sub;
  logic       load, last;
  slot_t      cur;

  assign load = !token_valid || token_ready;
  assign last = (sub == head.count - 2'd1);
  assign pop  = load && !q_empty && last;

  always_comb begin
    case (sub)
      2'd0:    cur = head.slot[0];
      2'd1:    cur = head.slot[1];
      default: cur = head.slot[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
      sub         <= 2'd0;
    end else if (load) begin
      token_valid <= !q_empty;
      if (!q_empty) sub <= last ? 2'd0 : sub + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      token.token_kind   <= cur.kind;
      token.start_offset <= cur.start_offset;
      token.end_offset   <= cur.end_offset;
      token.run_last     <= last;
    end
  end

endmodule

// ----- design/sexpr_tokenizer.sv -----
// Top level of the s-expression tokenizer: front end, entry queue, back end.
// Depends on sxt_pkg, sxt_front, sxt_queue and sxt_back.
//
// Usage: text bytes enter on the item channel (item_valid/item_ready, one
// byte per transfer, is_final on the last byte of a text). Tokens leave on
// the token channel (token_valid/token_ready), one token per transfer with
// kind, start and end offsets, and run_last on the last token of a byte.
// A byte is taken every cycle while the queue has room; it produces zero
// to three tokens, and the back end sends one token per cycle while the
// receiver is ready, so the sustained rate is one byte per cycle as long
// as bytes average at most one token, set by the single output register
// of the back end; each token is stored in the queue before that register.
// When the receiver stalls, the output register holds its token, the queue
// (QUEUE_DEPTH entries, one per token-producing byte) fills, and then
// item_ready drops. Bytes that make no token never enter the queue.
// Reset clears scan mode and offsets to the start of a new text and
// empties the queue; after a final byte the next byte starts at offset 0.
module sexpr_tokenizer import sxt_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   item_valid,
  output logic   item_ready,
  input  item_t  item,
  output logic   token_valid,
  input  logic   token_ready,
  output token_t token
);

  logic   q_full, q_empty, push, pop;
  entry_t push_entry, head;

  sxt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_full     (q_full),
    .push       (push),
    .entry      (push_entry)
  );

  sxt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  sxt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_empty     (q_empty),
    .pop         (pop),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token       (token)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full) else $error("push into full queue");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty)) else $error("queue both full and empty");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (token_valid && token.token_kind == KIND_END) |-> token.run_last)
    else $error("end token not last of its byte");

  a_offset_order: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> (token.start_offset <= token.end_offset))
    else $error("token ends before it starts");

endmodule
